// ===== hw/rtl/mmcs_pkg.sv =====
package mmcs_pkg;

  localparam int ValW    = 33;
  localparam int RawW    = 32;
  localparam int AluW    = 42;
  localparam int GrayW   = 8;
  localparam int CfgIdxW = 3;
  localparam int NumW    = 41;
  localparam int DshW    = 40;
  localparam int FmtW    = 3;

  localparam logic signed [ValW-1:0] ValMax = 33'sh0_FFFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin = 33'sh1_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_FORMAT   = 3'd0,
    REG_USE_FIXED_LOW  = 3'd1,
    REG_USE_FIXED_HIGH = 3'd2,
    REG_FIXED_LOW      = 3'd3,
    REG_FIXED_HIGH     = 3'd4
  } cfg_reg_t;

  typedef enum logic [FmtW-1:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_U16 = 3'd2,
    FMT_S32 = 3'd3,
    FMT_U32 = 3'd4
  } pix_fmt_t;

  typedef enum logic [0:0] {
    CMD_SCAN = 1'b0,
    CMD_MAP  = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_LO,
    ST_SCAN_HI,
    ST_RANGE,
    ST_CLIP_LO,
    ST_CLIP_HI,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [FmtW-1:0]        pixel_format;
    logic                   use_fixed_low;
    logic                   use_fixed_high;
    logic signed [ValW-1:0] fixed_low;
    logic signed [ValW-1:0] fixed_high;
  } cfg_t;

  typedef struct packed {
    logic lt;
    logic zero;
  } alu_flags_t;

  function automatic logic signed [AluW-1:0] widen(input logic signed [ValW-1:0] x);
    return {{(AluW-ValW){x[ValW-1]}}, x};
  endfunction

  function automatic logic signed [ValW-1:0] decode_pixel(input logic [FmtW-1:0] fmt,
                                                         input logic [RawW-1:0] raw);
    logic signed [ValW-1:0] v;
    case (pix_fmt_t'(fmt))
      FMT_U8:  v = {25'b0, raw[7:0]};
      FMT_S16: v = {{17{raw[15]}}, raw[15:0]};
      FMT_U16: v = {17'b0, raw[15:0]};
      FMT_S32: v = {raw[31], raw};
      FMT_U32: v = {1'b0, raw};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/minmax_contrast_stretch_gray_core.sv =====
// channel   dir  signals                    payload
// s_*       in   tvalid tready tdata tlast  tdata: pixel_raw; tuser: command, frame_start;
//                tuser                      tlast: frame_end
// m_*       out  tvalid tready tdata tlast  tdata: gray_level; tlast: last_pixel
// cfg_*     in   we index wdata             register write, no read-back
//
// scan request steps: accept plus two compares on the shared subtractor
// map request steps: accept, range, two clip steps, scale, 8 divide steps, output
// map request with an inverted range steps: accept, range, output
// the single subtract/compare unit sets the rate; s_tready is high only between requests
// a finished result waits in the output register; the next request is taken meanwhile
// rst is synchronous, clears sequencer, config and m_tvalid, presets running min to ValMax and max to ValMin

module minmax_contrast_stretch_gray_core
  import mmcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [RawW-1:0]    s_tdata,   // [31:0] pixel_raw
  input  logic               s_tlast,
  input  logic [1:0]         s_tuser,   // [0] command, [1] frame_start
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [GrayW-1:0]   m_tdata,   // [7:0] gray_level
  output logic               m_tlast,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ValW-1:0]    cfg_wdata
);

  cfg_t                   cfg;
  state_t                 st, st_next;
  logic signed [ValW-1:0] v;
  logic                   start_f;
  logic                   last_f;
  logic signed [ValW-1:0] running_low;
  logic signed [ValW-1:0] running_high;
  logic [ValW-1:0]        dlt;
  logic [ValW-1:0]        d;
  logic [NumW-1:0]        rem;
  logic [DshW-1:0]        dsh;
  logic [GrayW-1:0]       q;
  logic [2:0]             cnt;
  logic signed [ValW-1:0] lo_sel, hi_sel;
  logic signed [AluW-1:0] alu_a, alu_b, alu_diff;
  alu_flags_t             flags;
  logic                   s_fire;
  logic                   out_load;

  mmcs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mmcs_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .diff  (alu_diff),
    .flags (flags)
  );

  assign lo_sel   = cfg.use_fixed_low  ? cfg.fixed_low  : running_low;
  assign hi_sel   = cfg.use_fixed_high ? cfg.fixed_high : running_high;
  assign s_tready = (st == ST_IDLE) && !rst;
  assign s_fire   = s_tvalid && s_tready;
  assign out_load = (st == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    alu_a   = '0;
    alu_b   = '0;
    case (st)
      ST_IDLE: begin
        if (s_fire) begin
          st_next = (cmd_t'(s_tuser[0]) == CMD_MAP) ? ST_RANGE : ST_SCAN_LO;
        end
      end
      ST_SCAN_LO: begin
        alu_a   = widen(v);
        alu_b   = widen(running_low);
        st_next = ST_SCAN_HI;
      end
      ST_SCAN_HI: begin
        alu_a   = widen(running_high);
        alu_b   = widen(v);
        st_next = ST_IDLE;
      end
      ST_RANGE: begin
        alu_a   = widen(hi_sel);
        alu_b   = widen(lo_sel);
        st_next = flags.lt ? ST_DONE : ST_CLIP_LO;
      end
      ST_CLIP_LO: begin
        alu_a   = widen(v);
        alu_b   = widen(lo_sel);
        st_next = ST_CLIP_HI;
      end
      ST_CLIP_HI: begin
        alu_a   = {9'b0, dlt};
        alu_b   = {9'b0, d};
        st_next = ST_SCALE;
      end
      ST_SCALE: begin
        alu_a   = {1'b0, d, 8'b0};
        alu_b   = {9'b0, d};
        st_next = ST_DIV;
      end
      ST_DIV: begin
        alu_a = {1'b0, rem};
        alu_b = {2'b0, dsh};
        if (cnt == '0) begin
          st_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // running min and max
  always_ff @(posedge clk) begin
    if (rst) begin
      running_low  <= ValMax;
      running_high <= ValMin;
    end else if (st == ST_SCAN_LO) begin
      if (start_f || flags.lt) begin
        running_low <= v;
      end
      if (start_f) begin
        running_high <= v;
      end
    end else if (st == ST_SCAN_HI && flags.lt) begin
      running_high <= v;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (s_fire) begin
      v       <= decode_pixel(cfg.pixel_format, s_tdata);
      start_f <= s_tuser[1];
      last_f  <= s_tlast;
    end
    case (st)
      ST_RANGE: begin
        q   <= '1;
        dlt <= flags.zero ? ValW'(1) : alu_diff[ValW-1:0];
      end
      ST_CLIP_LO: d <= flags.lt ? '0 : alu_diff[ValW-1:0];
      ST_CLIP_HI: begin
        if (flags.lt) begin
          d <= dlt;
        end
      end
      ST_SCALE: begin
        rem <= alu_diff[NumW-1:0];
        dsh <= {dlt, 7'b0};
        cnt <= 3'd7;
      end
      ST_DIV: begin
        if (!flags.lt) begin
          rem <= alu_diff[NumW-1:0];
        end
        q   <= {q[GrayW-2:0], !flags.lt};
        dsh <= dsh >> 1;
        cnt <= cnt - 3'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= q;
      m_tlast <= last_f;
    end
  end

`ifndef SYNTH
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV && cnt == '0) |=> (st == ST_DONE))
    else $error("divide did not end after eight steps");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SCAN_HI) |=> (running_low <= running_high))
    else $error("running min above running max after scan");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV) |-> ({1'b0, rem} < {dsh, 1'b0}))
    else $error("remainder out of range in divide");

  a_clip: assert property (@(posedge clk) disable iff (rst)
    (st == ST_CLIP_HI) |=> (d <= dlt))
    else $error("clipped offset above range");
`endif

endmodule

// ===== hw/rtl/mmcs_alu.sv =====
module mmcs_alu
  import mmcs_pkg::*;
(
  input  logic signed [AluW-1:0] a,
  input  logic signed [AluW-1:0] b,
  output logic signed [AluW-1:0] diff,
  output alu_flags_t             flags
);

  logic signed [AluW:0] full;

  assign full       = {a[AluW-1], a} - {b[AluW-1], b};
  assign diff       = full[AluW-1:0];
  assign flags.lt   = full[AluW];
  assign flags.zero = (full == '0);

endmodule

// ===== hw/rtl/mmcs_cfg.sv =====
module mmcs_cfg
  import mmcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ValW-1:0]    cfg_wdata,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PIXEL_FORMAT:   cfg.pixel_format   <= cfg_wdata[FmtW-1:0];
        REG_USE_FIXED_LOW:  cfg.use_fixed_low  <= cfg_wdata[0];
        REG_USE_FIXED_HIGH: cfg.use_fixed_high <= cfg_wdata[0];
        REG_FIXED_LOW:      cfg.fixed_low      <= cfg_wdata;
        REG_FIXED_HIGH:     cfg.fixed_high     <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule
